@@ rtl/phdd_pkg.sv @@
// phdd_pkg: shared constants and types of the page-hinkley drift detector
// field widths, register reset values, register indexes and item codes
// no dependencies
package phdd_pkg;

	// default widths of the sample path and of the cumulative sums
	localparam int unsigned SAMPLE_WIDTH_DEF = 32;
	localparam int unsigned SUM_WIDTH_DEF    = 48;

	// fixed field widths
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned DELTA_W    = 31;
	localparam int unsigned LAMBDA_W   = 47;
	localparam int unsigned WARMUP_W   = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 47;

	// register reset values
	localparam logic [DELTA_W-1:0]  TOLERANCE_RESET = '0;
	localparam logic [LAMBDA_W-1:0] THRESHOLD_RESET = LAMBDA_W'(3276800);
	localparam logic [WARMUP_W-1:0] WARMUP_RESET    = WARMUP_W'(30);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_WARMUP    = 2'd2
	} cfg_reg_t;

	// item codes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

endpackage

@@ rtl/phdd_if.sv @@
// phdd_if: valid/ready channels of the page-hinkley drift detector
// item, result and configuration channels; depends on phdd_pkg

interface phdd_item_if #(
	parameter int unsigned SAMPLE_WIDTH = phdd_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, op, sample, input ready);
	modport sink (input valid, op, sample, output ready);
endinterface

interface phdd_result_if #(
	parameter int unsigned SAMPLE_WIDTH = phdd_pkg::SAMPLE_WIDTH_DEF
);
	import phdd_pkg::*;

	logic                           valid;
	logic                           ready;
	logic                           drift;
	logic signed [SAMPLE_WIDTH-1:0] mean;
	logic [CNT_W-1:0]               count;

	modport source (output valid, drift, mean, count, input ready);
	modport sink (input valid, drift, mean, count, output ready);
endinterface

interface phdd_cfg_if;
	import phdd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/page_hinkley_drift_detector.sv @@
// page_hinkley_drift_detector: page-hinkley concept-drift detector, Q16.16
// running mean through a bit-serial restoring divider, saturating cusum and minimum
// depends on phdd_pkg and the channel interfaces in phdd_if
//
//   channel  dir  handshake      payload
//   cfg      in   valid/ready    index, data (register write, always ready)
//   item     in   valid/ready    op, sample
//   result   out  valid/ready    drift, mean, count
//
// a sample steps from item acceptance through the restoring divider, one quotient bit per
// cycle, then through the mean, term, sum, minimum and result load steps; a clear goes
// straight from acceptance to the result load; the next item is taken after the load
// the result register parts the two sides: an item is taken while a result waits,
// and only the result load stalls until the previous result has been taken
// arst_n clears the detector state and restores the register reset values

module page_hinkley_drift_detector #(
	parameter int unsigned SAMPLE_WIDTH = phdd_pkg::SAMPLE_WIDTH_DEF,
	parameter int unsigned SUM_WIDTH    = phdd_pkg::SUM_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	phdd_cfg_if.sink        cfg,
	phdd_item_if.sink       item,
	phdd_result_if.source   result
);
	import phdd_pkg::*;

	localparam int unsigned SW     = SAMPLE_WIDTH;
	localparam int unsigned SUMW   = SUM_WIDTH;
	localparam int unsigned TERM_W = ((SW > DELTA_W) ? SW : DELTA_W) + 2;
	localparam int unsigned ACC_W  = ((SUMW > TERM_W) ? SUMW : TERM_W) + 1;
	localparam int unsigned GAP_W  = (SUMW > LAMBDA_W) ? SUMW : LAMBDA_W;
	localparam int unsigned BIT_W  = $clog2(SW + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MEAN,
		S_TERM,
		S_SUM,
		S_MIN,
		S_FIN
	} state_t;

	// control and detector state
	state_t                  state_q;
	logic [BIT_W-1:0]        div_cnt_q;
	logic signed [SW-1:0]    mean_q;
	logic signed [SUMW-1:0]  cusum_q;
	logic signed [SUMW-1:0]  cmin_q;
	logic [CNT_W-1:0]        obs_q;

	// configuration registers
	logic [DELTA_W-1:0]      tol_q;
	logic [LAMBDA_W-1:0]     thr_q;
	logic [WARMUP_W-1:0]     warmup_q;

	// datapath registers
	logic signed [SW-1:0]    sample_q;
	logic                    neg_q;
	logic [SW-1:0]           dvd_q;
	logic [CNT_W-1:0]        rem_q;
	logic signed [TERM_W-1:0] term_q;
	logic [SUMW-1:0]         gap_q;

	// result register
	logic                    out_valid_q;
	logic                    drift_q;
	logic signed [SW-1:0]    out_mean_q;
	logic [CNT_W-1:0]        out_count_q;

	logic                    item_ok;
	logic                    result_free;
	logic [CNT_W-1:0]        cnt_inc;
	logic signed [SW:0]      diff;
	logic [SW:0]             diff_abs;
	logic [CNT_W:0]          trial;
	logic                    fits;
	logic [CNT_W:0]          rem_next;
	logic signed [SW:0]      q_s;
	logic signed [SW:0]      mean_sum;
	logic signed [TERM_W-1:0] s_ext;
	logic signed [TERM_W-1:0] m_ext;
	logic signed [TERM_W-1:0] t_ext;
	logic signed [TERM_W-1:0] term_calc;
	logic signed [ACC_W-1:0] acc;
	logic                    acc_ovf;
	logic signed [SUMW-1:0]  sum_sat;
	logic signed [SUMW-1:0]  cmin_next;
	logic [SUMW:0]           gap_calc;
	logic                    drift_calc;

	// handshakes
	assign item.ready   = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign item_ok      = item.valid && item.ready;
	assign result_free  = !out_valid_q || result.ready;

	assign result.valid = out_valid_q;
	assign result.drift = drift_q;
	assign result.mean  = out_mean_q;
	assign result.count = out_count_q;

	// saturating count and sample minus old mean
	assign cnt_inc  = (obs_q == '1) ? obs_q : obs_q + CNT_W'(1);
	assign diff     = {item.sample[SW-1], item.sample} - {mean_q[SW-1], mean_q};
	assign diff_abs = diff[SW] ? -diff : diff;

	// one restoring division step against the count
	assign trial    = {rem_q, dvd_q[SW-1]};
	assign fits     = (trial >= {1'b0, obs_q});
	assign rem_next = fits ? (trial - {1'b0, obs_q}) : trial;

	// signed quotient truncated toward zero, new mean
	assign q_s      = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign mean_sum = $signed({mean_q[SW-1], mean_q}) + q_s;

	// sample minus new mean minus tolerance
	assign s_ext     = TERM_W'(sample_q);
	assign m_ext     = TERM_W'(mean_q);
	assign t_ext     = TERM_W'(tol_q);
	assign term_calc = s_ext - m_ext - t_ext;

	// saturating cumulative sum
	assign acc     = ACC_W'(cusum_q) + ACC_W'(term_q);
	assign acc_ovf = (acc[ACC_W-1:SUMW-1] != {(ACC_W - SUMW + 1){acc[ACC_W-1]}});
	assign sum_sat = !acc_ovf ? acc[SUMW-1:0] :
		acc[ACC_W-1] ? {1'b1, {(SUMW - 1){1'b0}}} : {1'b0, {(SUMW - 1){1'b1}}};

	// running minimum and gap above it
	assign cmin_next = (cusum_q < cmin_q) ? cusum_q : cmin_q;
	assign gap_calc  = {cusum_q[SUMW-1], cusum_q} - {cmin_next[SUMW-1], cmin_next};

	// alarm decision
	assign drift_calc = (obs_q >= CNT_W'(warmup_q)) && (GAP_W'(gap_q) > GAP_W'(thr_q));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOLERANCE_RESET;
			thr_q    <= THRESHOLD_RESET;
			warmup_q <= WARMUP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_TOLERANCE: tol_q    <= cfg.data[DELTA_W-1:0];
				REG_THRESHOLD: thr_q    <= cfg.data[LAMBDA_W-1:0];
				REG_WARMUP:    warmup_q <= cfg.data[WARMUP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, detector state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			mean_q      <= '0;
			cusum_q     <= '0;
			cmin_q      <= '0;
			obs_q       <= '0;
			out_valid_q <= 1'b0;
			drift_q     <= 1'b0;
			out_mean_q  <= '0;
			out_count_q <= '0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_ok) begin
						if (item.op == OP_CLEAR) begin
							mean_q  <= '0;
							cusum_q <= '0;
							cmin_q  <= '0;
							obs_q   <= '0;
							state_q <= S_FIN;
						end else begin
							obs_q     <= cnt_inc;
							div_cnt_q <= BIT_W'(SW);
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - BIT_W'(1);
					if (div_cnt_q == BIT_W'(1)) begin
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					mean_q  <= mean_sum[SW-1:0];
					state_q <= S_TERM;
				end
				S_TERM: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					cusum_q <= sum_sat;
					state_q <= S_MIN;
				end
				S_MIN: begin
					cmin_q  <= cmin_next;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (result_free) begin
						out_valid_q <= 1'b1;
						drift_q     <= drift_calc;
						out_mean_q  <= mean_q;
						out_count_q <= obs_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: dividend/quotient shift register, remainder, term and gap
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_ok) begin
					sample_q <= item.sample;
					neg_q    <= diff[SW];
					dvd_q    <= diff_abs[SW-1:0];
					rem_q    <= '0;
					gap_q    <= '0;
				end
			end
			S_DIV: begin
				dvd_q <= {dvd_q[SW-2:0], fits};
				rem_q <= rem_next[CNT_W-1:0];
			end
			S_TERM: begin
				term_q <= term_calc;
			end
			S_MIN: begin
				gap_q <= gap_calc[SUMW-1:0];
			end
			default: ;
		endcase
	end

	// the minimum never lies above the sum between items
	a_min_below_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cmin_q <= cusum_q))
		else $error("cusum minimum above cusum");

	// an alarm needs at least one observation
	a_drift_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.drift) |-> (result.count != '0))
		else $error("drift flagged with zero count");

	// an empty detector reports a zero mean and no alarm
	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.count == '0)) |-> ((result.mean == '0) && !result.drift))
		else $error("nonzero result with zero count");

	// a result appears only from the load step
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result loaded outside the load step");

endmodule
